>>> rtl/core/adhc_pkg.sv
package adhc_pkg;

  localparam int DEF_VALUE_BITS = 32;
  localparam int MAX_OUT        = 10;
  localparam int EMIT_W         = $clog2(MAX_OUT + 1);
  localparam int QUEUE_DEPTH    = 2;

  localparam logic [7:0] CH_MINUS    = 8'h2D;
  localparam logic [7:0] CH_X        = 8'h78;
  localparam logic [7:0] CH_ZERO     = 8'h30;
  localparam logic [7:0] CH_NINE     = 8'h39;
  localparam logic [7:0] CH_UPPER_A  = 8'h41;
  localparam logic [7:0] CH_UPPER_F  = 8'h46;
  // 'A' minus ten, so that glyph = base + digit for digits ten and up
  localparam logic [7:0] CH_ALPHA_BASE = 8'h37;

  typedef struct packed {
    logic [7:0] char_code;
    logic       token_end;
  } in_word_t;

  typedef struct packed {
    logic [7:0] out_char;
    logic       out_last;
  } out_word_t;

  // decimal digits needed for any value of the given width (ceil of bits * log10 2)
  function automatic int dec_digits(input int bits);
    return (bits * 30103 + 99999) / 100000;
  endfunction

  function automatic logic [3:0] dec_digit(input logic [7:0] c);
    logic [3:0] d;
    d = 4'd0;
    if (c inside {[CH_ZERO:CH_NINE]}) d = 4'(c - CH_ZERO);
    return d;
  endfunction

  function automatic logic [3:0] hex_digit(input logic [7:0] c);
    logic [3:0] d;
    d = 4'd0;
    if (c inside {[CH_ZERO:CH_NINE]}) d = 4'(c - CH_ZERO);
    else if (c inside {[CH_UPPER_A:CH_UPPER_F]}) d = 4'(c - CH_ALPHA_BASE);
    return d;
  endfunction

  function automatic logic [7:0] hex_glyph(input logic [3:0] d);
    logic [7:0] g;
    if (d < 4'd10) g = CH_ZERO + 8'(d);
    else g = CH_ALPHA_BASE + 8'(d);
    return g;
  endfunction

endpackage

>>> rtl/core/adhc_front.sv
module adhc_front #(
  parameter int VALUE_BITS = adhc_pkg::DEF_VALUE_BITS
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  adhc_pkg::in_word_t   in_word,
  output logic                 push_valid,
  output logic [VALUE_BITS:0]  push_data,
  input  logic                 q_full
);
  import adhc_pkg::*;

  typedef enum logic [1:0] {
    MODE_DEC  = 2'd0,
    MODE_ZERO = 2'd1,
    MODE_HEX  = 2'd2,
    MODE_NEG  = 2'd3
  } mode_t;

  logic [VALUE_BITS-1:0] acc_r, acc_nxt;
  logic [1:0]            pos_r, pos_nxt;
  mode_t                 mode_r, mode_nxt;
  logic                  accept;

  assign in_stall = q_full;
  assign accept   = in_valid && !in_stall;

  always_comb begin
    acc_nxt  = acc_r;
    mode_nxt = mode_r;
    if (pos_r == 2'd0) begin
      if (in_word.char_code == CH_MINUS) begin
        mode_nxt = MODE_NEG;
      end else if (in_word.char_code == CH_ZERO) begin
        mode_nxt = MODE_ZERO;
        acc_nxt  = '0;
      end else begin
        mode_nxt = MODE_DEC;
        acc_nxt  = VALUE_BITS'(dec_digit(in_word.char_code));
      end
    end else if (mode_r == MODE_ZERO && pos_r == 2'd1 && in_word.char_code == CH_X) begin
      mode_nxt = MODE_HEX;
      acc_nxt  = '0;
    end else if (mode_r == MODE_HEX) begin
      acc_nxt = (acc_r << 4) + VALUE_BITS'(hex_digit(in_word.char_code));
    end else if (mode_r != MODE_NEG) begin
      // times ten as two shifts and an add, wrapping at the value width
      mode_nxt = MODE_DEC;
      acc_nxt  = (acc_r << 3) + (acc_r << 1) + VALUE_BITS'(dec_digit(in_word.char_code));
    end
    pos_nxt = (pos_r < 2'd2) ? pos_r + 2'd1 : pos_r;
  end

  // negative tokens are dropped here and never reach the queue
  assign push_valid = accept && in_word.token_end && (mode_nxt != MODE_NEG);
  assign push_data  = {mode_nxt == MODE_HEX, acc_nxt};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      acc_r  <= '0;
      pos_r  <= 2'd0;
      mode_r <= MODE_DEC;
    end else if (accept) begin
      if (in_word.token_end) begin
        acc_r  <= '0;
        pos_r  <= 2'd0;
        mode_r <= MODE_DEC;
      end else begin
        acc_r  <= acc_nxt;
        pos_r  <= pos_nxt;
        mode_r <= mode_nxt;
      end
    end
  end

  assert property (@(posedge clk) disable iff (!rst_n)
    pos_r != 2'd3)
    else $error("character position passed saturation");

  assert property (@(posedge clk) disable iff (!rst_n)
    (accept && in_word.token_end) |=> (pos_r == 2'd0 && acc_r == '0))
    else $error("token state not cleared after token end");

  assert property (@(posedge clk) disable iff (!rst_n)
    (mode_r == MODE_HEX) |-> (pos_r == 2'd2))
    else $error("hex mode entered before the prefix was complete");

endmodule

>>> rtl/core/adhc_queue.sv
module adhc_queue #(
  parameter int WIDTH = 33
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push_valid,
  input  logic [WIDTH-1:0] push_data,
  output logic             q_full,
  output logic             q_valid,
  input  logic             q_pop,
  output logic [WIDTH-1:0] q_data
);
  import adhc_pkg::*;

  localparam int PTR_W = $clog2(QUEUE_DEPTH);
  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

  logic [WIDTH-1:0] entry_r [QUEUE_DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, rd_ptr_r;
  logic [CNT_W-1:0] cnt_r;
  logic             do_push, do_pop;

  assign q_full  = (cnt_r == CNT_W'(QUEUE_DEPTH));
  assign q_valid = (cnt_r != '0);
  assign q_data  = entry_r[rd_ptr_r];
  assign do_push = push_valid && !q_full;
  assign do_pop  = q_pop && q_valid;

  always_ff @(posedge clk) begin
    if (do_push) entry_r[wr_ptr_r] <= push_data;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (do_push) wr_ptr_r <= (wr_ptr_r == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
      if (do_pop)  rd_ptr_r <= (rd_ptr_r == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
      if (do_push && !do_pop) cnt_r <= cnt_r + 1'b1;
      else if (do_pop && !do_push) cnt_r <= cnt_r - 1'b1;
    end
  end

  assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= CNT_W'(QUEUE_DEPTH))
    else $error("queue count beyond depth");

  assert property (@(posedge clk) disable iff (!rst_n)
    (do_push && !do_pop) |=> (cnt_r == $past(cnt_r) + 1'b1))
    else $error("queue count missed a push");

  assert property (@(posedge clk) disable iff (!rst_n)
    (cnt_r == '0) |-> (wr_ptr_r == rd_ptr_r))
    else $error("queue pointers differ while empty");

endmodule

>>> rtl/core/adhc_back.sv
module adhc_back #(
  parameter int VALUE_BITS = adhc_pkg::DEF_VALUE_BITS
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 q_valid,
  input  logic [VALUE_BITS:0]  q_data,
  output logic                 q_pop,
  output logic                 out_valid,
  input  logic                 out_stall,
  output adhc_pkg::out_word_t  out_word
);
  import adhc_pkg::*;

  localparam int NDIG  = dec_digits(VALUE_BITS);
  localparam int DIG_W = NDIG * 4;
  localparam int REM_W = $clog2(NDIG + 1);
  localparam int CNT_W = $clog2(VALUE_BITS + 1);

  typedef enum logic [2:0] {
    S_IDLE,
    S_BCD,
    S_SKIP,
    S_PRE0,
    S_PREX,
    S_EMIT
  } state_t;

  state_t                state_r;
  logic [VALUE_BITS-1:0] bin_r;
  logic [DIG_W-1:0]      dig_r, dig_adj;
  logic [CNT_W-1:0]      cnt_r;
  logic [REM_W-1:0]      rem_r;
  logic [EMIT_W-1:0]     emit_r;
  logic                  hexout_r;
  logic                  out_valid_r;
  out_word_t             out_word_r;
  logic                  out_free;
  logic                  emit_now;
  logic [3:0]            top_dig;
  logic                  last_char;

  assign out_valid = out_valid_r;
  assign out_word  = out_word_r;
  assign out_free  = !out_valid_r || !out_stall;
  assign emit_now  = out_free && (state_r inside {S_PRE0, S_PREX, S_EMIT});
  assign q_pop     = (state_r == S_IDLE) && q_valid;
  assign top_dig   = dig_r[DIG_W-1 -: 4];
  assign last_char = (rem_r == REM_W'(1)) || (emit_r == EMIT_W'(MAX_OUT - 1));

  // double dabble: every bcd digit of five or more gets three added before the shift
  always_comb begin
    for (int i = 0; i < NDIG; i++) begin
      dig_adj[i*4 +: 4] = (dig_r[i*4 +: 4] >= 4'd5) ? dig_r[i*4 +: 4] + 4'd3
                                                    : dig_r[i*4 +: 4];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
      emit_r      <= '0;
    end else begin
      if (emit_now) out_valid_r <= 1'b1;
      else if (!out_stall) out_valid_r <= 1'b0;
      case (state_r)
        S_IDLE: begin
          if (q_valid) begin
            rem_r  <= REM_W'(NDIG);
            emit_r <= '0;
            if (q_data[VALUE_BITS]) begin
              // hex token, answer in decimal
              bin_r    <= q_data[VALUE_BITS-1:0];
              dig_r    <= '0;
              cnt_r    <= CNT_W'(VALUE_BITS);
              hexout_r <= 1'b0;
              state_r  <= S_BCD;
            end else begin
              dig_r    <= DIG_W'(q_data[VALUE_BITS-1:0]);
              hexout_r <= 1'b1;
              state_r  <= S_SKIP;
            end
          end
        end
        S_BCD: begin
          dig_r <= {dig_adj[DIG_W-2:0], bin_r[VALUE_BITS-1]};
          bin_r <= {bin_r[VALUE_BITS-2:0], 1'b0};
          cnt_r <= cnt_r - 1'b1;
          if (cnt_r == CNT_W'(1)) state_r <= S_SKIP;
        end
        S_SKIP: begin
          if (top_dig == 4'd0 && rem_r != REM_W'(1)) begin
            dig_r <= {dig_r[DIG_W-5:0], 4'h0};
            rem_r <= rem_r - 1'b1;
          end else begin
            state_r <= hexout_r ? S_PRE0 : S_EMIT;
          end
        end
        S_PRE0: begin
          if (out_free) begin
            out_word_r  <= '{out_char: CH_ZERO, out_last: 1'b0};
            emit_r      <= emit_r + 1'b1;
            state_r     <= S_PREX;
          end
        end
        S_PREX: begin
          if (out_free) begin
            out_word_r  <= '{out_char: CH_X, out_last: 1'b0};
            emit_r      <= emit_r + 1'b1;
            state_r     <= S_EMIT;
          end
        end
        S_EMIT: begin
          if (out_free) begin
            out_word_r  <= '{out_char: hex_glyph(top_dig), out_last: last_char};
            dig_r       <= {dig_r[DIG_W-5:0], 4'h0};
            rem_r       <= rem_r - 1'b1;
            emit_r      <= emit_r + 1'b1;
            if (last_char) state_r <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_BCD) |-> (cnt_r != '0))
    else $error("conversion running with no bits left");

  assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_SKIP || state_r == S_EMIT) |-> (rem_r != '0))
    else $error("digit count ran out");

  assert property (@(posedge clk) disable iff (!rst_n)
    emit_r <= EMIT_W'(MAX_OUT))
    else $error("answer longer than the cap");

  assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_IDLE && q_valid) |=> (state_r != S_IDLE))
    else $error("job popped but not started");

endmodule

>>> rtl/core/ascii_decimal_hex_converter.sv
// flow: after the last word of a token its job is written into the queue; the back pops
//   it, converts a hex token in S_BCD (bit-serial bcd), skips leading zeros in S_SKIP
//   and then registers the first answer word
// throughput: one character per cycle until the two-entry job queue fills; answers
//   leave one word per cycle while out_stall is low, at most ten per token
// reset: synchronous active-low rst_n clears token state, queue and output valid
module ascii_decimal_hex_converter #(
  parameter int VALUE_BITS = adhc_pkg::DEF_VALUE_BITS
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  input  adhc_pkg::in_word_t  in_word,
  output logic                out_valid,
  input  logic                out_stall,
  output adhc_pkg::out_word_t out_word
);
  import adhc_pkg::*;

  // front: classifies each character (decimal, leading zero, hex, negative) and
  // accumulates the value; on token end it posts {hex flag, value} as one job unless the token is negative
  logic                  push_valid;
  logic [VALUE_BITS:0]   push_data;
  logic                  q_full;
  logic                  q_valid;
  logic                  q_pop;
  logic [VALUE_BITS:0]   q_data;

  adhc_front #(
    .VALUE_BITS (VALUE_BITS)
  ) u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .in_word    (in_word),
    .push_valid (push_valid),
    .push_data  (push_data),
    .q_full     (q_full)
  );

  // short job queue so the front keeps taking characters while answers drain
  adhc_queue #(
    .WIDTH (VALUE_BITS + 1)
  ) u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (push_valid),
    .push_data  (push_data),
    .q_full     (q_full),
    .q_valid    (q_valid),
    .q_pop      (q_pop),
    .q_data     (q_data)
  );

  // back: bcd conversion for hex tokens, leading-zero skip, then one word per cycle, held
  // by out_stall, through the output register, with the 0x prefix for decimal tokens
  adhc_back #(
    .VALUE_BITS (VALUE_BITS)
  ) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_valid   (q_valid),
    .q_data    (q_data),
    .q_pop     (q_pop),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_word  (out_word)
  );

endmodule
